[hdl/b64e_pkg.sv]
`timescale 1ns / 1ps

package b64e_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UPPER = 8'h41;
  localparam logic [7:0] CHAR_LOWER = 8'h61;
  localparam logic [7:0] CHAR_DIGIT = 8'h30;

  localparam logic FUNC_ENCODE = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] chars;
  } job_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_stat_t;

  function automatic logic [7:0] sym(input logic [5:0] v);
    logic [7:0] r;
    case (v) inside
      [6'd0:6'd25]:  r = CHAR_UPPER + {2'b00, v};
      [6'd26:6'd51]: r = CHAR_LOWER + {2'b00, v} - 8'd26;
      [6'd52:6'd61]: r = CHAR_DIGIT + {2'b00, v} - 8'd52;
      6'd62:         r = CHAR_PLUS;
      default:       r = CHAR_SLASH;
    endcase
    return r;
  endfunction

endpackage

[hdl/base64_stream_encoder.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  func, data_byte
// output    out        out_valid/out_stall  out_char, last
//
// A data byte or finish is taken while the job queue has room.
// Characters leave one per cycle from the back register while out_stall is low: a byte gives one or two,
// a finish zero, two or three, so an item yields zero to three characters.
// With an idle back, a job's first character is valid once it has passed through the queue into the back register.
// Reset clears phase, carry, queue pointers and the back's busy flag and index.
// A full queue raises in_stall: output stalls or jobs of two or three characters fill it.

module base64_stream_encoder #(
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       func,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last
);
  import b64e_pkg::*;

  logic        accept;
  logic        push;
  logic        pop_req;
  job_t        push_job;
  job_t        pop_job;
  queue_stat_t q_stat;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;

  b64e_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .func      (func),
    .data_byte (data_byte),
    .push      (push),
    .job       (push_job)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop_req  (pop_req),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_job     (pop_job),
    .q_stat    (q_stat),
    .pop_req   (pop_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

endmodule

[hdl/b64e_front.sv]
`timescale 1ns / 1ps

module b64e_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          func,
  input  logic [7:0]    data_byte,
  output logic          push,
  output b64e_pkg::job_t job
);
  import b64e_pkg::*;

  typedef enum logic [1:0] {PH0, PH1, PH2} phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] carry;
  logic [3:0] carry_next;

  always_comb begin
    job        = '0;
    phase_next = phase;
    carry_next = carry;
    if (func == FUNC_ENCODE) begin
      carry_next = data_byte[3:0];
      case (phase)
        PH1: begin
          job.count    = 2'd1;
          job.chars[0] = sym({carry[1:0], data_byte[7:4]});
          phase_next   = PH2;
        end
        PH2: begin
          job.count    = 2'd2;
          job.chars[0] = sym({carry, data_byte[7:6]});
          job.chars[1] = sym(data_byte[5:0]);
          phase_next   = PH0;
        end
        default: begin
          job.count    = 2'd1;
          job.chars[0] = sym(data_byte[7:2]);
          phase_next   = PH1;
        end
      endcase
    end else begin
      carry_next = 4'd0;
      phase_next = PH0;
      case (phase)
        PH1: begin
          job.count    = 2'd3;
          job.chars[0] = sym({carry[1:0], 4'd0});
          job.chars[1] = PAD_CHAR;
          job.chars[2] = PAD_CHAR;
        end
        PH2: begin
          job.count    = 2'd2;
          job.chars[0] = sym({carry, 2'd0});
          job.chars[1] = PAD_CHAR;
        end
        default: begin
          job.count = 2'd0;
        end
      endcase
    end
  end

  assign push = accept && (job.count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH0;
      carry <= 4'd0;
    end else if (accept) begin
      phase <= phase_next;
      carry <= carry_next;
    end
  end

`ifndef SYNTHESIS
  a_push_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> job.count != 2'd0)
    else $error("empty job pushed");
  a_finish_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_FINISH) |=> (phase == PH0 && carry == 4'd0))
    else $error("finish did not return to group start");
  a_encode_count: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_ENCODE) |-> (job.count == 2'd1 || job.count == 2'd2))
    else $error("bad character count for data byte");
`endif

endmodule

[hdl/b64e_queue.sv]
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64e_pkg::job_t        push_job,
  input  logic                  pop_req,
  output b64e_pkg::job_t        pop_job,
  output b64e_pkg::queue_stat_t stat
);
  import b64e_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign stat.full      = (count == FULL_CNT);
  assign stat.not_empty = (count != '0);
  assign pop            = pop_req && stat.not_empty;
  assign pop_job        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full))
    else $error("push into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("queue count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push && count == CNT_W'(1)) |=> !stat.not_empty)
    else $error("queue not empty after last pop");
`endif

endmodule

[hdl/b64e_back.sv]
`timescale 1ns / 1ps

module b64e_back (
  input  logic                  clk,
  input  logic                  rst,
  input  b64e_pkg::job_t        q_job,
  input  b64e_pkg::queue_stat_t q_stat,
  output logic                  pop_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  last
);
  import b64e_pkg::*;

  logic       busy;
  job_t       cur;
  logic [1:0] idx;
  logic       xfer;
  logic       done;

  assign out_valid = busy;
  assign out_char  = cur.chars[idx];
  assign last      = (idx == cur.count - 2'd1);
  assign xfer      = busy && !out_stall;
  assign done      = xfer && last;
  assign pop_req   = !busy || done;

  always_ff @(posedge clk) begin
    if (pop_req) begin
      cur <= q_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop_req) begin
      busy <= q_stat.not_empty;
      idx  <= 2'd0;
    end else if (xfer) begin
      idx <= idx + 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (xfer && !last) |=> out_valid)
    else $error("job dropped before final character");
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx < cur.count))
    else $error("character index beyond job");
  a_refill: assert property (@(posedge clk) disable iff (rst)
    (pop_req && q_stat.not_empty) |=> (busy && idx == 2'd0))
    else $error("queued job not taken");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import b64e_pkg::*;

  typedef enum logic [1:0] {
    GRP_FIRST,
    GRP_SECOND,
    GRP_THIRD
  } grp_phase_t;

  class b64_scoreboard;
    grp_phase_t  grp_phase;
    logic [3:0]  carry;
    logic [7:0]  char_q[$];
    logic        last_q[$];
    int          errors;

    function new();
      grp_phase = GRP_FIRST;
      carry     = 4'h0;
      errors    = 0;
    endfunction

    function logic [7:0] symbol(input logic [5:0] v);
      string alpha;
      alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return alpha[v];
    endfunction

    function void push(input logic [7:0] ch, input logic lst);
      char_q.push_back(ch);
      last_q.push_back(lst);
    endfunction

    function int pending();
      return char_q.size();
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    // Predict the characters caused by one accepted transfer.
    function void note_input(input logic fn, input logic [7:0] b);
      if (fn == FUNC_ENCODE) begin
        case (grp_phase)
          GRP_SECOND: begin
            push(symbol({carry[1:0], b[7:4]}), 1'b1);
            grp_phase = GRP_THIRD;
          end
          GRP_THIRD: begin
            push(symbol({carry, b[7:6]}), 1'b0);
            push(symbol(b[5:0]), 1'b1);
            grp_phase = GRP_FIRST;
          end
          default: begin
            push(symbol(b[7:2]), 1'b1);
            grp_phase = GRP_SECOND;
          end
        endcase
        carry = b[3:0];
      end else begin
        case (grp_phase)
          GRP_SECOND: begin
            push(symbol({carry[1:0], 4'h0}), 1'b0);
            push(PAD_CHAR, 1'b0);
            push(PAD_CHAR, 1'b1);
          end
          GRP_THIRD: begin
            push(symbol({carry, 2'b00}), 1'b0);
            push(PAD_CHAR, 1'b1);
          end
          default: ;
        endcase
        grp_phase = GRP_FIRST;
        carry     = 4'h0;
      end
    endfunction

    task check_char(input logic [7:0] ch, input logic lst);
      logic [7:0] exp_ch;
      logic       exp_last;
      if (char_q.size() == 0) begin
        report($sformatf("unexpected char %h last %b", ch, lst));
      end else begin
        exp_ch   = char_q.pop_front();
        exp_last = last_q.pop_front();
        if (ch !== exp_ch)
          report($sformatf("out_char %h, expected %h", ch, exp_ch));
        if (lst !== exp_last)
          report($sformatf("last %b, expected %b (char %h)", lst, exp_last, exp_ch));
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       func = FUNC_ENCODE;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       last;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  b64_scoreboard sb = new();

  base64_stream_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last      (last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_input(func, data_byte);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_char(out_char, last);
  end

  // Hold the transfer until it is taken.
  task send_item(input logic fn, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= fn;
    data_byte <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task send_encode(input logic [7:0] b);
    send_item(FUNC_ENCODE, b);
  endtask

  task send_finish(input logic [7:0] b);
    send_item(FUNC_FINISH, b);
  endtask

  task send_random(input int count);
    int grp_len;
    int k;
    while (count > 0) begin
      if ($urandom_range(9) == 0) begin
        send_item(logic'($urandom_range(1)), 8'($urandom));
        count--;
      end else begin
        grp_len = $urandom_range(7);
        for (k = 0; k < grp_len && count > 0; k++) begin
          send_encode(8'($urandom));
          count--;
        end
        if (count > 0) begin
          send_finish(8'($urandom));
          count--;
        end
      end
    end
  endtask

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_finish(8'hFF);
    send_encode(8'h00);
    send_finish(8'hFF);
    send_encode(8'hFF);
    send_encode(8'hFF);
    send_finish(8'h00);
    send_encode(8'hFF);
    send_encode(8'hFF);
    send_encode(8'hFF);
    send_finish(8'hA5);
    send_finish(8'h5A);
    send_encode(8'h4D);
    send_encode(8'h61);
    send_encode(8'h6E);
    send_encode(8'h00);
    send_encode(8'h00);
    send_encode(8'h00);
    send_encode(8'hFB);
    send_encode(8'hEF);
    send_finish(8'h00);
    send_encode(8'hF8);
    send_finish(8'hFF);
    send_finish(8'h00);

    send_random(75);
    send_idle_pct = 55;
    send_random(75);
    send_idle_pct  = 0;
    recv_stall_pct = 55;
    send_random(75);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    send_random(75);

    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d chars never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
